FILE: sv/bgma_pkg.sv
// ----------------------------------------------------------------------------
// bgma_pkg
// Shared types, sizes and codes of the binary grid majority automaton.
// ----------------------------------------------------------------------------
package bgma_pkg;

    // grid limits and derived store sizes
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CELLS_W    = $clog2(DEPTH + 1);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int COL_W      = $clog2(MAX_WIDTH + 2);

    // word field widths
    localparam int OP_W  = 2;
    localparam int GEN_W = 8;
    localparam int DIM_W = 7;
    localparam int CNT_W = 4;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = DIM_W;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'd1;
    localparam int GRID_W_RST = 64;
    localparam int GRID_H_RST = 64;

    // a cell flips when at least this many window places hold the other type
    localparam int FLIP_THRESHOLD = 5;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_RUN   = 2'd2
    } t_opcode;

    // which row of the window the previous-generation read serves
    typedef enum logic [1:0] {
        RSEL_UP  = 2'd0,
        RSEL_MID = 2'd1,
        RSEL_DN  = 2'd2
    } t_rsel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_WRITE,
        ST_READ_WAIT,
        ST_GEN_CHECK,
        ST_COPY,
        ST_COPY_END,
        ST_FETCH_UP,
        ST_FETCH_MID,
        ST_FETCH_DN,
        ST_SHIFT,
        ST_UPDATE,
        ST_NEXT_ROW,
        ST_GEN_END,
        ST_RESP
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic  latch_in;
        logic  cell_wr;
        logic  copy_start;
        logic  copy_rd;
        logic  gen_start;
        t_rsel rsel;
        logic  cap_up;
        logic  cap_mid;
        logic  shift;
        logic  cell_upd;
        logic  row_next;
        logic  gen_dec;
        logic  load_out;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            gens_zero;
        logic            copy_last;
        logic            prime;
        logic            row_end;
        logic            last_row;
        logic            out_free;
    } t_stat;

    // register value as used: zero reads as one, above the limit as the limit
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] lim);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (v > lim) begin
            res = lim;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

FILE: sv/bgma_in_if.sv
// ----------------------------------------------------------------------------
// bgma_in_if
// Command channel: valid/ready handshake carrying one command word.
// ----------------------------------------------------------------------------
interface bgma_in_if;
    import bgma_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [ADDR_W-1:0] cell_addr;
    logic              cell_value;
    logic [GEN_W-1:0]  generations;

    modport source (output valid, opcode, cell_addr, cell_value, generations,
                    input ready);
    modport sink (input valid, opcode, cell_addr, cell_value, generations,
                  output ready);
endinterface

FILE: sv/bgma_out_if.sv
// ----------------------------------------------------------------------------
// bgma_out_if
// Response channel: valid/ready handshake carrying one completion word.
// ----------------------------------------------------------------------------
interface bgma_out_if;
    import bgma_pkg::*;

    logic            valid;
    logic            ready;
    logic            read_value;
    logic [OP_W-1:0] done_kind;

    modport source (output valid, read_value, done_kind, input ready);
    modport sink (input valid, read_value, done_kind, output ready);
endinterface

FILE: sv/bgma_ctrl.sv
// ----------------------------------------------------------------------------
// bgma_ctrl
// Sequencer: decodes commands and walks the copy and update sweeps of a run.
// ----------------------------------------------------------------------------
module bgma_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  bgma_pkg::t_stat i_stat,
    output bgma_pkg::t_cmd  o_cmd
);
    import bgma_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                unique case (i_stat.op)
                    OP_WRITE: n_state = ST_WRITE;
                    OP_READ:  n_state = ST_READ_WAIT;
                    OP_RUN:   n_state = ST_GEN_CHECK;
                    default:  n_state = ST_IDLE;
                endcase
            end
            ST_WRITE:     n_state = ST_RESP;
            ST_READ_WAIT: n_state = ST_RESP;
            ST_GEN_CHECK: begin
                n_state = i_stat.gens_zero ? ST_RESP : ST_COPY;
            end
            ST_COPY: begin
                if (i_stat.copy_last) n_state = ST_COPY_END;
            end
            ST_COPY_END:  n_state = ST_FETCH_UP;
            ST_FETCH_UP:  n_state = ST_FETCH_MID;
            ST_FETCH_MID: n_state = ST_FETCH_DN;
            ST_FETCH_DN:  n_state = ST_SHIFT;
            ST_SHIFT: begin
                n_state = i_stat.prime ? ST_FETCH_UP : ST_UPDATE;
            end
            ST_UPDATE: begin
                if (!i_stat.row_end) begin
                    n_state = ST_FETCH_UP;
                end else if (i_stat.last_row) begin
                    n_state = ST_GEN_END;
                end else begin
                    n_state = ST_NEXT_ROW;
                end
            end
            ST_NEXT_ROW: n_state = ST_FETCH_UP;
            ST_GEN_END:  n_state = ST_GEN_CHECK;
            ST_RESP: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // commands to the datapath
    always_comb begin
        o_cmd      = '0;
        o_cmd.rsel = RSEL_UP;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.latch_in = i_in_valid;
            end
            ST_WRITE:     o_cmd.cell_wr = 1'b1;
            ST_GEN_CHECK: o_cmd.copy_start = !i_stat.gens_zero;
            ST_COPY:      o_cmd.copy_rd = 1'b1;
            ST_COPY_END:  o_cmd.gen_start = 1'b1;
            ST_FETCH_UP:  o_cmd.rsel = RSEL_UP;
            ST_FETCH_MID: begin
                o_cmd.rsel   = RSEL_MID;
                o_cmd.cap_up = 1'b1;
            end
            ST_FETCH_DN: begin
                o_cmd.rsel    = RSEL_DN;
                o_cmd.cap_mid = 1'b1;
            end
            ST_SHIFT:    o_cmd.shift = 1'b1;
            ST_UPDATE:   o_cmd.cell_upd = 1'b1;
            ST_NEXT_ROW: o_cmd.row_next = 1'b1;
            ST_GEN_END:  o_cmd.gen_dec = 1'b1;
            ST_RESP:     o_cmd.load_out = i_stat.out_free;
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

FILE: sv/bgma_dp.sv
// ----------------------------------------------------------------------------
// bgma_dp
// Datapath: cell store, previous-generation copy, 3x3 window and output word.
// ----------------------------------------------------------------------------
module bgma_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bgma_pkg::t_cmd                    i_cmd,
    output bgma_pkg::t_stat                   o_stat,
    input  logic                              i_cfg_we,
    input  logic [bgma_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bgma_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [bgma_pkg::OP_W-1:0]         i_opcode,
    input  logic [bgma_pkg::ADDR_W-1:0]       i_cell_addr,
    input  logic                              i_cell_value,
    input  logic [bgma_pkg::GEN_W-1:0]        i_generations,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic                              o_read_value,
    output logic [bgma_pkg::OP_W-1:0]         o_done_kind
);
    import bgma_pkg::*;

    localparam int RST_USED_W = (GRID_W_RST > MAX_WIDTH) ? MAX_WIDTH : GRID_W_RST;
    localparam int RST_USED_H = (GRID_H_RST > MAX_HEIGHT) ? MAX_HEIGHT : GRID_H_RST;
    localparam logic [DIM_W-1:0] LIM_W = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] LIM_H = DIM_W'(MAX_HEIGHT);

    // configuration registers and the cell count they give
    logic [DIM_W-1:0]   r_width_raw;
    logic [DIM_W-1:0]   r_height_raw;
    logic [CELLS_W-1:0] r_cells;
    logic [DIM_W-1:0]   used_w;
    logic [DIM_W-1:0]   used_h;
    logic [DIM_W-1:0]   n_used_w;
    logic [DIM_W-1:0]   n_used_h;
    logic [2*DIM_W-1:0] cells_prod;

    // latched command word
    logic [OP_W-1:0]    r_op;
    logic [ADDR_W-1:0]  r_idx;
    logic               r_val;
    logic [GEN_W-1:0]   r_gens;
    logic               in_range;

    // stores
    logic               r_grid_mem [DEPTH];
    logic               r_prev_mem [DEPTH];
    logic               r_grd;
    logic               r_prd;
    logic               grid_we;
    logic [ADDR_W-1:0]  grid_wa;
    logic               grid_wd;
    logic [ADDR_W-1:0]  grid_ra;
    logic [ADDR_W-1:0]  prev_ra;

    // copy sweep
    logic [ADDR_W-1:0]  r_cp_i;
    logic               r_cp_we;
    logic [ADDR_W-1:0]  r_cp_addr;

    // update sweep
    logic [ROW_W-1:0]   r_row;
    logic [COL_W-1:0]   r_col;
    logic [ADDR_W-1:0]  r_base;
    logic [ADDR_W:0]    base_k;
    logic [ADDR_W:0]    w_ext;
    logic [ADDR_W-1:0]  up_a;
    logic [ADDR_W-1:0]  mid_a;
    logic [ADDR_W-1:0]  dn_a;
    logic [ADDR_W-1:0]  upd_a;
    logic               col_ok;
    logic               dn_ok;

    // window: bit 0 row above, bit 1 own row, bit 2 row below
    logic               r_cap_up;
    logic               r_cap_mid;
    logic [2:0]         r_lft_b;
    logic [2:0]         r_mid_b;
    logic [2:0]         r_rgt_b;
    logic [2:0]         r_lft_v;
    logic [2:0]         r_mid_v;
    logic [2:0]         r_rgt_v;
    logic [7:0]         diff;
    logic [CNT_W-1:0]   other_cnt;
    logic               own;
    logic               new_val;

    // output word
    logic               r_out_valid;
    logic               r_read_value;
    logic [OP_W-1:0]    r_done_kind;

    // used dimensions, and the ones a pending write would give
    assign used_w   = clamp_dim(r_width_raw, LIM_W);
    assign used_h   = clamp_dim(r_height_raw, LIM_H);
    assign n_used_w = (i_cfg_we && i_cfg_index == CFG_WIDTH) ?
                      clamp_dim(i_cfg_data, LIM_W) : used_w;
    assign n_used_h = (i_cfg_we && i_cfg_index == CFG_HEIGHT) ?
                      clamp_dim(i_cfg_data, LIM_H) : used_h;
    assign cells_prod = (2*DIM_W)'(n_used_w) * (2*DIM_W)'(n_used_h);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_raw  <= DIM_W'(GRID_W_RST);
            r_height_raw <= DIM_W'(GRID_H_RST);
            r_cells      <= CELLS_W'(RST_USED_W * RST_USED_H);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WIDTH:  r_width_raw  <= i_cfg_data;
                CFG_HEIGHT: r_height_raw <= i_cfg_data;
                default:    r_width_raw  <= r_width_raw;
            endcase
            r_cells <= CELLS_W'(cells_prod);
        end
    end

    // command word capture and generation count
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_op   <= i_opcode;
            r_idx  <= i_cell_addr;
            r_val  <= i_cell_value;
            r_gens <= i_generations;
        end else if (i_cmd.gen_dec) begin
            r_gens <= r_gens - GEN_W'(1);
        end
    end

    assign in_range = {1'b0, r_idx} < r_cells;

    // copy sweep counter and delayed write into the previous generation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cp_we <= 1'b0;
        end else begin
            r_cp_we <= i_cmd.copy_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.copy_start) begin
            r_cp_i <= '0;
        end else if (i_cmd.copy_rd) begin
            r_cp_i <= r_cp_i + ADDR_W'(1);
        end
        r_cp_addr <= r_cp_i;
    end

    // window addresses in the previous generation
    assign w_ext  = (ADDR_W+1)'(used_w);
    assign base_k = {1'b0, r_base} + (ADDR_W+1)'(r_col);
    assign mid_a  = base_k[ADDR_W-1:0];
    assign up_a   = ADDR_W'(base_k - w_ext);
    assign dn_a   = ADDR_W'(base_k + w_ext);
    assign upd_a  = ADDR_W'(base_k - (ADDR_W+1)'(2));

    always_comb begin
        unique case (i_cmd.rsel)
            RSEL_UP:  prev_ra = up_a;
            RSEL_MID: prev_ra = mid_a;
            RSEL_DN:  prev_ra = dn_a;
            default:  prev_ra = mid_a;
        endcase
    end

    // row and column walk of the update sweep
    always_ff @(posedge i_clk) begin
        if (i_cmd.gen_start) begin
            r_row  <= '0;
            r_col  <= '0;
            r_base <= '0;
        end else if (i_cmd.row_next) begin
            r_row  <= r_row + ROW_W'(1);
            r_col  <= '0;
            r_base <= r_base + ADDR_W'(used_w);
        end else if (i_cmd.shift) begin
            r_col  <= r_col + COL_W'(1);
        end
    end

    // bounds of the fetched column
    assign col_ok = r_col < COL_W'(used_w);
    assign dn_ok  = (DIM_W'(r_row) + DIM_W'(1)) < used_h;

    // window capture and shift
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_up) r_cap_up <= r_prd;
        if (i_cmd.cap_mid) r_cap_mid <= r_prd;
        if (i_cmd.shift) begin
            r_lft_b <= r_mid_b;
            r_mid_b <= r_rgt_b;
            r_rgt_b <= {r_prd, r_cap_mid, r_cap_up};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.gen_start || i_cmd.row_next) begin
            r_lft_v <= '0;
            r_mid_v <= '0;
            r_rgt_v <= '0;
        end else if (i_cmd.shift) begin
            r_lft_v <= r_mid_v;
            r_mid_v <= r_rgt_v;
            r_rgt_v <= {col_ok && dn_ok, col_ok, col_ok && (r_row != '0)};
        end
    end

    // neighbours of the other type; off-grid places never differ
    assign own  = r_mid_b[1];
    assign diff = {r_rgt_v & (r_rgt_b ^ {3{own}}),
                   r_mid_v[2] & (r_mid_b[2] ^ own),
                   r_mid_v[0] & (r_mid_b[0] ^ own),
                   r_lft_v & (r_lft_b ^ {3{own}})};

    always_comb begin
        other_cnt = '0;
        for (int j = 0; j < 8; j++) begin
            other_cnt = other_cnt + CNT_W'(diff[j]);
        end
    end

    assign new_val = own ^ (other_cnt >= CNT_W'(FLIP_THRESHOLD));

    // cell store ports
    always_comb begin
        grid_we = 1'b0;
        grid_wa = r_idx;
        grid_wd = r_val;
        if (i_cmd.cell_wr) begin
            grid_we = in_range;
        end else if (i_cmd.cell_upd) begin
            grid_we = 1'b1;
            grid_wa = upd_a;
            grid_wd = new_val;
        end
    end

    assign grid_ra = i_cmd.copy_rd ? r_cp_i : r_idx;

    always_ff @(posedge i_clk) begin
        if (grid_we) r_grid_mem[grid_wa] <= grid_wd;
        r_grd <= r_grid_mem[grid_ra];
    end

    // previous-generation store
    always_ff @(posedge i_clk) begin
        if (r_cp_we) r_prev_mem[r_cp_addr] <= r_grd;
        r_prd <= r_prev_mem[prev_ra];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_read_value <= (r_op == OP_READ) && in_range && r_grd;
            r_done_kind  <= r_op;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_read_value;
    assign o_done_kind  = r_done_kind;

    // status to the controller
    assign o_stat.op        = r_op;
    assign o_stat.gens_zero = (r_gens == '0);
    assign o_stat.copy_last = ({1'b0, r_cp_i} == (r_cells - CELLS_W'(1)));
    assign o_stat.prime     = (r_col == '0);
    assign o_stat.row_end   = (r_col == (COL_W'(used_w) + COL_W'(1)));
    assign o_stat.last_row  = ((DIM_W'(r_row) + DIM_W'(1)) == used_h);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

endmodule

FILE: sv/binary_grid_majority_automaton.sv
// ----------------------------------------------------------------------------
// binary_grid_majority_automaton
// Grid of one-bit cells with write, read and majority-rule generation runs.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake      word
//  i_cmd     in   valid/ready    opcode, cell_addr, cell_value, generations
//  o_rsp     out  valid/ready    read_value, done_kind
//  i_cfg_*   in   write enable   grid_width (index 0), grid_height (index 1)
//
//  write and read pass through decode, write or read wait and response in turn.
//  each generation of a run first copies all C = W * H cells into the
//  previous-generation store, then does three single-port reads and one update
//  write per cell, one at a time through that store's read port.
//  one command is in flight at a time; a finished word waits in the output register.
//  reset is synchronous and sets control state and grid size; stores hold until written.
//
module binary_grid_majority_automaton (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    bgma_in_if.sink                         i_cmd,
    bgma_out_if.source                      o_rsp,
    input  logic                            i_cfg_we,
    input  logic [bgma_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bgma_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bgma_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencer
    bgma_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (i_cmd.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // stores, window and output register
    bgma_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_opcode      (i_cmd.opcode),
        .i_cell_addr   (i_cmd.cell_addr),
        .i_cell_value  (i_cmd.cell_value),
        .i_generations (i_cmd.generations),
        .i_out_ready   (o_rsp.ready),
        .o_out_valid   (o_rsp.valid),
        .o_read_value  (o_rsp.read_value),
        .o_done_kind   (o_rsp.done_kind)
    );

endmodule

FILE: sv/bgma_checker.sv
// ----------------------------------------------------------------------------
// bgma_sva
// Port-level checks of the automaton, bound to the top level.
// ----------------------------------------------------------------------------
module bgma_sva (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_cmd_valid,
    input logic                        i_cmd_ready,
    input logic                        i_rsp_valid,
    input logic                        i_rsp_ready,
    input logic                        i_rsp_read_value,
    input logic [bgma_pkg::OP_W-1:0]   i_rsp_done_kind
);
    import bgma_pkg::*;

    // a stalled word holds its payload
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable(i_rsp_read_value) && $stable(i_rsp_done_kind))
        else $error("response word changed while stalled");

    // one command at a time: no accept in the cycle after an accept
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && i_cmd_ready |=> !i_cmd_ready)
        else $error("command taken while another was in flight");

    // only completed commands are echoed
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |->
            (i_rsp_done_kind == OP_WRITE || i_rsp_done_kind == OP_READ ||
             i_rsp_done_kind == OP_RUN))
        else $error("response for an ignored opcode");

    // only a read returns a cell
    a_rd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_done_kind != OP_READ |-> !i_rsp_read_value)
        else $error("read value set on a non-read response");

endmodule

bind binary_grid_majority_automaton bgma_sva u_bgma_sva (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_cmd_valid      (i_cmd.valid),
    .i_cmd_ready      (i_cmd.ready),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_rsp_read_value (o_rsp.read_value),
    .i_rsp_done_kind  (o_rsp.done_kind)
);
